FILE: hdl/plf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plf_pkg: shared types and codes for the point-to-line foot engine
// Holds the line classification codes that steer the result selection.
// ----------------------------------------------------------------------------
package plf_pkg;

   typedef logic [1:0] mode_type;

   // line classification
   localparam mode_type MODE_GENERAL    = 2'd0;
   localparam mode_type MODE_VERTICAL   = 2'd1;
   localparam mode_type MODE_HORIZONTAL = 2'd2;

endpackage
`default_nettype wire

FILE: hdl/point_line_foot.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle while the result word is empty or being taken;
// every stage then takes a new word, and the two one-bit-per-stage restoring
// dividers set the latency.
// The whole pipeline advances together and holds while the result word is not taken.
// Reset: synchronous, active high; clears all stage valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// point_line_foot: foot of the perpendicular from a point to a line
// Exact integer projection, truncated toward zero, saturated to the output
// range. Vertical and horizontal lines bypass the division path.
// ----------------------------------------------------------------------------
module point_line_foot #(
   parameter int COORD_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // line_start_x, line_start_y, line_end_x, line_end_y, point_x, point_y
   input  wire logic [((6*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // foot_x, foot_y
   output logic [((2*(COORD_BITS+3)+7)/8)*8-1:0] rsp_tdata,
   // saturated
   output logic [0:0] rsp_tuser
);

   localparam int C      = COORD_BITS;
   localparam int DW     = C + 1;            // coordinate differences
   localparam int PW     = 2 * DW;           // small products
   localparam int DDW    = 2 * DW + 1;       // squared length and dot product
   localparam int MW     = DW + DDW;         // dx * dot product
   localparam int QB     = C + 3;            // quotient bits of each divider
   localparam int OB     = C + 3;            // output coordinate width
   localparam int FXW    = C + 5;            // working foot coordinate width
   localparam int DVW    = MW + QB;          // first divider remainder width
   localparam int PDW    = DW + FXW + 1;     // dx * (fx - x0)
   localparam int NW     = PDW + 1;          // second numerator
   localparam int NRW    = NW + QB;          // second divider remainder width
   localparam int OTW    = ((2*OB+7)/8)*8;
   localparam int S_DIV1 = 5;
   localparam int S_FIX  = S_DIV1 + QB;
   localparam int S_DIV2 = S_FIX + 6;
   localparam int NS     = S_DIV2 + QB + 1;

   localparam logic signed [FXW-1:0] OUT_MAX = {{(FXW-OB+1){1'b0}}, {(OB-1){1'b1}}};
   localparam logic signed [FXW-1:0] OUT_MIN = {{(FXW-OB+1){1'b1}}, {(OB-1){1'b0}}};

   typedef struct packed {
      plf_pkg::mode_type       mode;
      logic signed [C-1:0]     x1;
      logic signed [C-1:0]     y1;
      logic signed [C-1:0]     x0;
      logic signed [C-1:0]     y0;
      logic signed [DW-1:0]    dx;
      logic signed [DW-1:0]    dy;
      logic signed [DW-1:0]    ax;
      logic signed [DW-1:0]    ay;
      logic signed [PW-1:0]    sq_x;
      logic signed [PW-1:0]    sq_y;
      logic signed [PW-1:0]    pt_x;
      logic signed [PW-1:0]    pt_y;
      logic signed [PW-1:0]    y0dy;
      logic signed [DDW-1:0]   dd2;
      logic signed [DDW-1:0]   dot;
      logic signed [MW-1:0]    m;
      logic                    neg;
      logic [DVW-1:0]          rem;
      logic [QB-1:0]           quot;
      logic signed [FXW-1:0]   fx;
      logic signed [FXW:0]     dfx;
      logic signed [PDW-1:0]   p;
      logic signed [NW-1:0]    num;
      logic                    nneg;
      logic                    ovf;
      logic [NRW-1:0]          nrem;
      logic [QB-1:0]           nquot;
      logic [OB-1:0]           foot_x;
      logic [OB-1:0]           foot_y;
      logic                    sat;
   } pipe_type;

   pipe_type pipe_ff [NS];
   pipe_type pipe_in [NS];
   logic     valid_ff [NS];
   logic     adv;

   // global advance: move when the result word is empty or being taken
   assign adv        = !valid_ff[NS-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tdata  = OTW'({pipe_ff[NS-1].foot_y, pipe_ff[NS-1].foot_x});
   assign rsp_tuser  = pipe_ff[NS-1].sat;

   // stage 0: unpack, differences, classification
   always_comb begin
      logic signed [C-1:0] x2;
      logic signed [C-1:0] y2;
      pipe_in[0]    = pipe_ff[0];
      pipe_in[0].x1 = req_tdata[0*C +: C];
      pipe_in[0].y1 = req_tdata[1*C +: C];
      x2            = req_tdata[2*C +: C];
      y2            = req_tdata[3*C +: C];
      pipe_in[0].x0 = req_tdata[4*C +: C];
      pipe_in[0].y0 = req_tdata[5*C +: C];
      pipe_in[0].dx = DW'(x2) - DW'(pipe_in[0].x1);
      pipe_in[0].dy = DW'(y2) - DW'(pipe_in[0].y1);
      pipe_in[0].ax = DW'(pipe_in[0].x0) - DW'(pipe_in[0].x1);
      pipe_in[0].ay = DW'(pipe_in[0].y0) - DW'(pipe_in[0].y1);
      priority if (x2 == pipe_in[0].x1) begin
         pipe_in[0].mode = plf_pkg::MODE_VERTICAL;
      end else if (y2 == pipe_in[0].y1) begin
         pipe_in[0].mode = plf_pkg::MODE_HORIZONTAL;
      end else begin
         pipe_in[0].mode = plf_pkg::MODE_GENERAL;
      end
   end

   // stage 1: products
   always_comb begin
      pipe_in[1]      = pipe_ff[0];
      pipe_in[1].sq_x = pipe_ff[0].dx * pipe_ff[0].dx;
      pipe_in[1].sq_y = pipe_ff[0].dy * pipe_ff[0].dy;
      pipe_in[1].pt_x = pipe_ff[0].ax * pipe_ff[0].dx;
      pipe_in[1].pt_y = pipe_ff[0].ay * pipe_ff[0].dy;
      pipe_in[1].y0dy = PW'(pipe_ff[0].y0) * PW'(pipe_ff[0].dy);
   end

   // stage 2: squared length and dot product
   always_comb begin
      pipe_in[2]     = pipe_ff[1];
      pipe_in[2].dd2 = DDW'(pipe_ff[1].sq_x) + DDW'(pipe_ff[1].sq_y);
      pipe_in[2].dot = DDW'(pipe_ff[1].pt_x) + DDW'(pipe_ff[1].pt_y);
   end

   // stage 3: offset numerator along x
   always_comb begin
      pipe_in[3]   = pipe_ff[2];
      pipe_in[3].m = MW'(pipe_ff[2].dx) * MW'(pipe_ff[2].dot);
   end

   // stage 4: magnitude for the first divider
   always_comb begin
      logic signed [MW-1:0] mag;
      pipe_in[4]      = pipe_ff[3];
      pipe_in[4].neg  = pipe_ff[3].m[MW-1];
      mag             = pipe_ff[3].m[MW-1] ? -pipe_ff[3].m : pipe_ff[3].m;
      pipe_in[4].rem  = DVW'($unsigned(mag));
      pipe_in[4].quot = '0;
   end

   // first divider: one quotient bit per stage, most significant first
   for (genvar j = 0; j < QB; j++) begin : g_div1
      always_comb begin
         logic [DVW-1:0] sub;
         pipe_in[S_DIV1+j] = pipe_ff[S_DIV1+j-1];
         sub = DVW'($unsigned(pipe_ff[S_DIV1+j-1].dd2)) << (QB-1-j);
         if (pipe_ff[S_DIV1+j-1].rem >= sub) begin
            pipe_in[S_DIV1+j].rem             = pipe_ff[S_DIV1+j-1].rem - sub;
            pipe_in[S_DIV1+j].quot[QB-1-j]    = 1'b1;
         end
      end
   end

   // floor of the offset, then truncation of x1 plus offset toward zero
   always_comb begin
      logic signed [FXW-1:0] q;
      logic signed [FXW-1:0] fl;
      logic                  rnz;
      pipe_in[S_FIX] = pipe_ff[S_FIX-1];
      rnz = (pipe_ff[S_FIX-1].rem != '0);
      q   = $signed(FXW'(pipe_ff[S_FIX-1].quot));
      if (pipe_ff[S_FIX-1].neg) begin
         q = -q;
      end
      fl = q + FXW'(pipe_ff[S_FIX-1].x1) - FXW'(pipe_ff[S_FIX-1].neg && rnz);
      pipe_in[S_FIX].fx = fl + FXW'(rnz && fl[FXW-1]);
   end

   // distance of the truncated foot from the query point along x
   always_comb begin
      pipe_in[S_FIX+1]     = pipe_ff[S_FIX];
      pipe_in[S_FIX+1].dfx = (FXW+1)'(pipe_ff[S_FIX].fx) - (FXW+1)'(pipe_ff[S_FIX].x0);
   end

   // dx times that distance
   always_comb begin
      pipe_in[S_FIX+2]   = pipe_ff[S_FIX+1];
      pipe_in[S_FIX+2].p = PDW'(pipe_ff[S_FIX+1].dx) * PDW'(pipe_ff[S_FIX+1].dfx);
   end

   // second numerator, sign folded so the divisor is positive
   always_comb begin
      logic signed [NW-1:0] n;
      pipe_in[S_FIX+3] = pipe_ff[S_FIX+2];
      n = NW'(pipe_ff[S_FIX+2].y0dy) - NW'(pipe_ff[S_FIX+2].p);
      pipe_in[S_FIX+3].num = pipe_ff[S_FIX+2].dy[DW-1] ? -n : n;
   end

   // magnitude for the second divider
   always_comb begin
      logic signed [NW-1:0] mag;
      pipe_in[S_FIX+4]       = pipe_ff[S_FIX+3];
      pipe_in[S_FIX+4].nneg  = pipe_ff[S_FIX+3].num[NW-1];
      mag = pipe_ff[S_FIX+3].num[NW-1] ? -pipe_ff[S_FIX+3].num : pipe_ff[S_FIX+3].num;
      pipe_in[S_FIX+4].nrem  = NRW'($unsigned(mag));
      pipe_in[S_FIX+4].nquot = '0;
   end

   // quotient too large for the divider width means the result clips
   always_comb begin
      logic [DW-1:0] ady;
      pipe_in[S_FIX+5] = pipe_ff[S_FIX+4];
      ady = pipe_ff[S_FIX+4].dy[DW-1] ? DW'(-pipe_ff[S_FIX+4].dy)
                                      : DW'(pipe_ff[S_FIX+4].dy);
      pipe_in[S_FIX+5].ovf = (pipe_ff[S_FIX+4].nrem >= (NRW'(ady) << QB));
   end

   // second divider: divides by the magnitude of dy
   for (genvar j = 0; j < QB; j++) begin : g_div2
      always_comb begin
         logic [DW-1:0]  ady;
         logic [NRW-1:0] sub;
         pipe_in[S_DIV2+j] = pipe_ff[S_DIV2+j-1];
         ady = pipe_ff[S_DIV2+j-1].dy[DW-1] ? DW'(-pipe_ff[S_DIV2+j-1].dy)
                                            : DW'(pipe_ff[S_DIV2+j-1].dy);
         sub = NRW'(ady) << (QB-1-j);
         if (pipe_ff[S_DIV2+j-1].nrem >= sub) begin
            pipe_in[S_DIV2+j].nrem          = pipe_ff[S_DIV2+j-1].nrem - sub;
            pipe_in[S_DIV2+j].nquot[QB-1-j] = 1'b1;
         end
      end
   end

   // result select and saturation into the output word
   always_comb begin
      logic signed [FXW-1:0] vx;
      logic signed [FXW-1:0] vy;
      logic signed [FXW-1:0] qy;
      logic                  sat;
      pipe_in[NS-1] = pipe_ff[NS-2];
      sat = 1'b0;
      qy  = $signed(FXW'(pipe_ff[NS-2].nquot));
      if (pipe_ff[NS-2].nneg) begin
         qy = -qy;
      end
      unique case (pipe_ff[NS-2].mode)
         plf_pkg::MODE_VERTICAL: begin
            vx = FXW'(pipe_ff[NS-2].x1);
            vy = FXW'(pipe_ff[NS-2].y0);
         end
         plf_pkg::MODE_HORIZONTAL: begin
            vx = FXW'(pipe_ff[NS-2].x0);
            vy = FXW'(pipe_ff[NS-2].y1);
         end
         default: begin
            vx = pipe_ff[NS-2].fx;
            if (pipe_ff[NS-2].ovf) begin
               vy  = pipe_ff[NS-2].nneg ? OUT_MIN : OUT_MAX;
               sat = 1'b1;
            end else begin
               vy = qy;
            end
         end
      endcase
      if (vx > OUT_MAX) begin
         vx  = OUT_MAX;
         sat = 1'b1;
      end else if (vx < OUT_MIN) begin
         vx  = OUT_MIN;
         sat = 1'b1;
      end
      if (vy > OUT_MAX) begin
         vy  = OUT_MAX;
         sat = 1'b1;
      end else if (vy < OUT_MIN) begin
         vy  = OUT_MIN;
         sat = 1'b1;
      end
      pipe_in[NS-1].foot_x = vx[OB-1:0];
      pipe_in[NS-1].foot_y = vy[OB-1:0];
      pipe_in[NS-1].sat    = sat;
   end

   // stage registers; valid bits travel with the payload
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= req_tvalid;
         for (int k = 1; k < NS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NS; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

endmodule
`default_nettype wire
